[hdl/octave_value_noise_2d_assert.svh]
// Assertion macros shared by the octave value noise block.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef OCTAVE_VALUE_NOISE_2D_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_ASSERT_SVH

// Condition must imply consequence in the same cycle
`define OVN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must imply consequence in the next cycle
`define OVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ovn_pkg.sv]
// Shared types and constants for the octave value noise block.
// No dependencies; imported by the interfaces and all modules.
package ovn_pkg;

  // Seed grid is GRID_SIZE x GRID_SIZE; a power of two
  localparam int GRID_SIZE   = 128;

  localparam int SEED_W      = 16;
  localparam int COORD_W     = 7;
  localparam int OCT_W       = 4;
  localparam int DECAY_W     = 16;
  localparam int NOISE_W     = 16;
  localparam int SAMPLE_W    = 20;
  localparam int FRAC_EXTRA  = 4;
  localparam int WEIGHT_FRAC = 12;
  localparam int DECAY_INT   = 4;
  localparam int WEIGHT_ONE  = 4096;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [OCT_W-1:0]   OCTAVES_RESET = 4'd4;
  localparam logic [DECAY_W-1:0] DECAY_RESET   = 16'd2048;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } ovn_op_t;

  typedef enum logic [0:0] {
    REG_OCTAVES = 1'b0,
    REG_DECAY   = 1'b1
  } ovn_reg_t;

  // Corners of the pitch cell: north row is y1, west column is x1
  typedef enum logic [1:0] {
    CORNER_NW = 2'd0,
    CORNER_NE = 2'd1,
    CORNER_SW = 2'd2,
    CORNER_SE = 2'd3
  } ovn_corner_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LAST,
    ST_LERPX,
    ST_LERPY,
    ST_MUL,
    ST_ADD,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } ovn_state_t;

  typedef struct packed {
    logic              wr_seed;
    logic              start;
    ovn_corner_t       corner;
    logic              shift_seed;
    logic              lerp_x;
    logic              lerp_y;
    logic              mul;
    logic              add;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic [OCT_W-1:0]  oct;
  } ovn_cmd_t;

  typedef struct packed {
    logic div_last;
  } ovn_status_t;

endpackage

[hdl/ovn_if.sv]
// Valid/ready stream interfaces for input words and result words.
// Depends on ovn_pkg for field widths.
interface ovn_in_if;
  import ovn_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [SEED_W-1:0]  seed_value;

  modport source (output valid, output operation, output x, output y, output seed_value,
                  input ready);
  modport sink   (input valid, input operation, input x, input y, input seed_value,
                  output ready);
endinterface

interface ovn_out_if;
  import ovn_pkg::*;

  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

[hdl/ovn_ctrl.sv]
// Controller state machine: sequences seed reads, lerps, accumulation and division.
// Depends on ovn_pkg and the assertion macro header.
`include "octave_value_noise_2d_assert.svh"

module ovn_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_op,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  input  logic [ovn_pkg::OCT_W-1:0]   cfg_octaves,
  input  ovn_pkg::ovn_status_t        status,
  output ovn_pkg::ovn_cmd_t           cmd
);
  import ovn_pkg::*;

  localparam int L    = $clog2(GRID_SIZE);
  localparam int MAXO = L + 1;

  ovn_state_t       state, state_next;
  logic [OCT_W-1:0] oct, oct_next;
  logic             out_valid_next;
  logic [OCT_W-1:0] n_eff;
  logic [OCT_W-1:0] last_oct;

  // Clamp the octave count to one through the count whose pitch is one
  always_comb begin
    if (cfg_octaves == '0) begin
      n_eff = OCT_W'(1);
    end else if (cfg_octaves > OCT_W'(MAXO)) begin
      n_eff = OCT_W'(MAXO);
    end else begin
      n_eff = cfg_octaves;
    end
    last_oct = n_eff - OCT_W'(1);
  end

  // State, octave counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      oct       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      oct       <= oct_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    oct_next   = oct;
    cmd        = '0;
    cmd.corner = CORNER_NW;
    cmd.oct    = oct;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.wr_seed = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            oct_next   = '0;
            state_next = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        cmd.corner = CORNER_NW;
        cmd.add    = 1'b1;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.corner     = CORNER_NE;
        cmd.shift_seed = 1'b1;
        state_next     = ST_RD2;
      end
      ST_RD2: begin
        cmd.corner     = CORNER_SW;
        cmd.shift_seed = 1'b1;
        state_next     = ST_RD3;
      end
      ST_RD3: begin
        cmd.corner     = CORNER_SE;
        cmd.shift_seed = 1'b1;
        state_next     = ST_LAST;
      end
      ST_LAST: begin
        cmd.shift_seed = 1'b1;
        state_next     = ST_LERPX;
      end
      ST_LERPX: begin
        cmd.lerp_x = 1'b1;
        state_next = ST_LERPY;
      end
      ST_LERPY: begin
        cmd.lerp_y = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (oct == last_oct) begin
          state_next = ST_ADD;
        end else begin
          oct_next   = oct + OCT_W'(1);
          state_next = ST_RD0;
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold the result until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = (out_valid & ~out_ready) | cmd.out_load;
  end

  `OVN_ASSERT_IMPLIES(a_load_free, cmd.out_load, (!out_valid || out_ready), "result overwritten")
  `OVN_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid, "loaded result not presented")
  `OVN_ASSERT_NEXT(a_div_len, (state == ST_DINIT), !status.div_last, "divider too short")
  `OVN_ASSERT_NEXT(a_start_oct, cmd.start, (oct == '0), "query did not start at octave zero")

endmodule

[hdl/ovn_dpath.sv]
// Datapath: seed memory, per-octave bilinear interpolation, weighting and divider.
// Depends on ovn_pkg; driven by commands from ovn_ctrl.
module ovn_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  ovn_pkg::ovn_cmd_t             cmd,
  output ovn_pkg::ovn_status_t          status,
  input  logic [ovn_pkg::COORD_W-1:0]   x,
  input  logic [ovn_pkg::COORD_W-1:0]   y,
  input  logic [ovn_pkg::SEED_W-1:0]    seed_value,
  input  logic [ovn_pkg::DECAY_W-1:0]   cfg_decay,
  output logic [ovn_pkg::NOISE_W-1:0]   noise_value
);
  import ovn_pkg::*;

  localparam int L     = $clog2(GRID_SIZE);
  localparam int CW    = L;
  localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
  localparam int PW    = L + 1;
  localparam int TOPW  = SEED_W + L;
  localparam int NUMW  = SEED_W + 2 * L;
  localparam int WW    = WEIGHT_FRAC + DECAY_INT * L;
  localparam int WSW   = WW + 1;
  localparam int PRODW = SAMPLE_W + WW;
  localparam int ACCW  = PRODW + 1;
  localparam int DPAD  = FRAC_EXTRA + NOISE_W - 1;
  localparam int DSW   = WSW + DPAD;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = 2 * CW;
  localparam int CNTW  = $clog2(NOISE_W + 1);

  logic [XW-1:0]       x_w, y_w;
  logic [CW-1:0]       x_in, y_in;
  logic [CW-1:0]       px, py;
  logic [OCT_W-1:0]    pl;
  logic [CW-1:0]       mask;
  logic [PW-1:0]       pitch;
  logic [CW-1:0]       x1, y1, x2, y2, dx, dy;
  logic [PW-1:0]       xsum, ysum;
  logic [PW-1:0]       wx0, wx1, wy0, wy1;
  logic [AW-1:0]       raddr, waddr;
  logic [SEED_W-1:0]   mem [DEPTH];
  logic [SEED_W-1:0]   rdata;
  logic [SEED_W-1:0]   seed_q [4];
  logic [SEED_W+PW-1:0] pt0, pt1, pb0, pb1;
  logic [TOPW-1:0]     top, bot;
  logic [TOPW+PW-1:0]  pn0, pn1;
  logic [NUMW-1:0]     num;
  logic [NUMW+FRAC_EXTRA-1:0] num_sh;
  logic [SAMPLE_W-1:0] sample;
  logic [PRODW-1:0]    prod;
  logic [WW-1:0]       w;
  logic [WW+DECAY_W-1:0] wd;
  logic [WSW-1:0]      wsum;
  logic [ACCW-1:0]     acc;
  logic [ACCW-1:0]     rem;
  logic [DSW-1:0]      dsh;
  logic                ge;
  logic [NOISE_W-1:0]  quot;
  logic [CNTW-1:0]     cnt;

  // Wrap incoming coordinates onto the grid
  assign x_w   = XW'(x);
  assign y_w   = XW'(y);
  assign x_in  = x_w[CW-1:0];
  assign y_in  = y_w[CW-1:0];
  assign waddr = {y_in, x_in};

  // Pitch cell corners and lerp weights for the current octave
  assign pl    = OCT_W'(L) - cmd.oct;
  assign mask  = ~({CW{1'b1}} << pl);
  assign pitch = {{(PW-1){1'b0}}, 1'b1} << pl;
  assign x1    = px & ~mask;
  assign y1    = py & ~mask;
  assign dx    = px & mask;
  assign dy    = py & mask;
  assign xsum  = {1'b0, x1} + pitch;
  assign ysum  = {1'b0, y1} + pitch;
  assign x2    = xsum[CW-1:0];
  assign y2    = ysum[CW-1:0];
  assign wx1   = {1'b0, dx};
  assign wy1   = {1'b0, dy};
  assign wx0   = pitch - wx1;
  assign wy0   = pitch - wy1;

  // Select the corner to read
  always_comb begin
    case (cmd.corner)
      CORNER_NW: raddr = {y1, x1};
      CORNER_NE: raddr = {y1, x2};
      CORNER_SW: raddr = {y2, x1};
      CORNER_SE: raddr = {y2, x2};
      default:   raddr = {y1, x1};
    endcase
  end

  // Seed memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_seed) begin
      mem[waddr] <= seed_value;
    end
    rdata <= mem[raddr];
  end

  // Interpolation arithmetic
  assign pt0    = seed_q[0] * wx0;
  assign pt1    = seed_q[1] * wx1;
  assign pb0    = seed_q[2] * wx0;
  assign pb1    = seed_q[3] * wx1;
  assign pn0    = top * wy0;
  assign pn1    = bot * wy1;
  assign num_sh = {num, {FRAC_EXTRA{1'b0}}} >> {pl, 1'b0};
  assign sample = num_sh[SAMPLE_W-1:0];
  assign wd     = w * cfg_decay;
  assign ge     = (rem >= ACCW'(dsh));

  // Octave pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px   <= x_in;
      py   <= y_in;
      acc  <= '0;
      wsum <= '0;
      w    <= WW'(WEIGHT_ONE);
      prod <= '0;
    end
    if (cmd.shift_seed) begin
      seed_q[0] <= seed_q[1];
      seed_q[1] <= seed_q[2];
      seed_q[2] <= seed_q[3];
      seed_q[3] <= rdata;
    end
    if (cmd.lerp_x) begin
      top <= TOPW'(pt0 + pt1);
      bot <= TOPW'(pb0 + pb1);
    end
    if (cmd.lerp_y) begin
      num <= NUMW'(pn0 + pn1);
    end
    // Weight the sample; advance weight and weight sum
    if (cmd.mul) begin
      prod <= sample * w;
      wsum <= wsum + WSW'(w);
      w    <= wd[WW+WEIGHT_FRAC-1:WEIGHT_FRAC];
    end
    if (cmd.add) begin
      acc <= acc + ACCW'(prod);
    end
    // Restoring division, one quotient bit per cycle
    if (cmd.div_init) begin
      rem  <= acc;
      dsh  <= {wsum, {DPAD{1'b0}}};
      quot <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - ACCW'(dsh);
      end
      quot <= {quot[NOISE_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
    if (cmd.out_load) begin
      noise_value <= quot;
    end
  end

  // Divider bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      cnt <= CNTW'(NOISE_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - CNTW'(1);
    end
  end

  assign status.div_last = (cnt == CNTW'(1));

endmodule

[hdl/octave_value_noise_2d.sv]
// Octave value noise: a load word writes one seed and loads follow back to back;
// a query word runs its octave steps, the final accumulation and the divider, and its
// result is loaded once the output register is free; the next word is taken only back
// in idle, after any wait of the query in its last step for the previous result to be taken.
// Per octave, four reads through the single seed memory read port are followed by the
// lerp and weight steps; the bit-serial divider then forms the quotient bit by bit.
module octave_value_noise_2d (
  input  logic                        clk,
  input  logic                        rst,
  ovn_in_if.sink                      item,
  ovn_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ovn_pkg::APB_AW-1:0]  paddr,
  input  logic [ovn_pkg::APB_DW-1:0]  pwdata,
  output logic [ovn_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ovn_pkg::*;

  // Synchronous reset sets octaves to 4 and decay to 2048; the seed memory is not cleared.
  logic [OCT_W-1:0]   octaves;
  logic [DECAY_W-1:0] octave_decay;
  ovn_reg_t           reg_sel;
  ovn_cmd_t           cmd;
  ovn_status_t        status;

  assign pready  = 1'b1;
  assign reg_sel = ovn_reg_t'(paddr[2]);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      octaves      <= OCTAVES_RESET;
      octave_decay <= DECAY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_OCTAVES: octaves      <= pwdata[OCT_W-1:0];
        REG_DECAY:   octave_decay <= pwdata[DECAY_W-1:0];
        default:     octaves      <= octaves;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_OCTAVES: prdata = APB_DW'(octaves);
      REG_DECAY:   prdata = APB_DW'(octave_decay);
      default:     prdata = '0;
    endcase
  end

  ovn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (item.valid),
    .in_op       (item.operation),
    .in_ready    (item.ready),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .cfg_octaves (octaves),
    .status      (status),
    .cmd         (cmd)
  );

  ovn_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .x           (item.x),
    .y           (item.y),
    .seed_value  (item.seed_value),
    .cfg_decay   (octave_decay),
    .noise_value (result.noise_value)
  );

endmodule
